/* rtl/core/rmt_pkg.sv */
// Shared types, widths and codes for the running median tracker.
`timescale 1ns / 1ps
package rmt_pkg;

  // Field widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MED_W    = 33;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Default store depth
  localparam int unsigned CAPACITY_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [MED_W-1:0]   med_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // Broadcast from the top level to every cell of the chain
  typedef struct packed {
    logic   ins;
    value_t value;
  } bcast_t;

endpackage

/* rtl/core/rmt_in_if.sv */
// Input channel interface: command and sample with valid/ready.
`timescale 1ns / 1ps
interface rmt_in_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  rmt_pkg::value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

/* rtl/core/rmt_out_if.sv */
// Result channel interface: doubled median, status and count with valid/ready.
`timescale 1ns / 1ps
interface rmt_out_if;
  logic             valid;
  logic             ready;
  rmt_pkg::med_t    median_doubled;
  rmt_pkg::status_t status;
  rmt_pkg::count_t  count;

  modport source (output valid, output median_doubled, output status, output count,
                  input ready);
  modport sink (input valid, input median_doubled, input status, input count,
                output ready);
endinterface

/* rtl/core/rmt_cell.sv */
// One cell of the sorted chain: holds a sample and its median tap flags.
`timescale 1ns / 1ps
module rmt_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rmt_pkg::bcast_t  bc,
  input  logic [CW-1:0]    count,
  input  logic [CW-1:0]    mid_nxt,
  input  logic             odd_nxt,
  input  logic             prev_take,
  input  rmt_pkg::value_t  prev_val,
  output logic             take,
  output rmt_pkg::value_t  val,
  output logic             sel_lo,
  output logic             sel_hi
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

  rmt_pkg::value_t val_r, val_nxt;
  logic            sel_lo_r, sel_lo_nxt;
  logic            sel_hi_r, sel_hi_nxt;

  // This cell is at or past the insertion point (new sample goes after equals)
  assign take = (count > IDX_C) ? (val_r > bc.value) : (count == IDX_C);

  // Shift in the left neighbor's sample, or take the new one at the boundary
  always_comb begin
    val_nxt = val_r;
    if (bc.ins && take) begin
      val_nxt = prev_take ? prev_val : bc.value;
    end
  end

  // Tap flags follow the count after this cycle's transfer
  assign sel_hi_nxt = (mid_nxt == IDX_C);
  assign sel_lo_nxt = odd_nxt ? (mid_nxt == IDX_C) : (mid_nxt == IDX1_C);

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_lo_r <= 1'b0;
      sel_hi_r <= 1'b0;
    end else begin
      sel_lo_r <= sel_lo_nxt;
      sel_hi_r <= sel_hi_nxt;
    end
  end

  assign val    = val_r;
  assign sel_lo = sel_lo_r;
  assign sel_hi = sel_hi_r;

endmodule

/* rtl/core/rmt_chain.sv */
// Row of sorted cells with AND-OR taps for the two middle samples.
`timescale 1ns / 1ps
module rmt_chain #(
  parameter int unsigned CAPACITY = rmt_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rmt_pkg::bcast_t bc,
  input  logic [CW-1:0]   count,
  input  logic [CW-1:0]   count_nxt,
  output rmt_pkg::value_t mid_lo,
  output rmt_pkg::value_t mid_hi
);

  logic [CW-1:0]   mid_nxt;
  logic            odd_nxt;
  logic            take   [CAPACITY];
  rmt_pkg::value_t val    [CAPACITY];
  logic            sel_lo [CAPACITY];
  logic            sel_hi [CAPACITY];

  // Middle position of the count that holds after this cycle
  assign mid_nxt = count_nxt >> 1;
  assign odd_nxt = count_nxt[0];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        rmt_cell #(.IDX(gi), .CW(CW)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .bc        (bc),
          .count     (count),
          .mid_nxt   (mid_nxt),
          .odd_nxt   (odd_nxt),
          .prev_take (1'b0),
          .prev_val  (bc.value),
          .take      (take[gi]),
          .val       (val[gi]),
          .sel_lo    (sel_lo[gi]),
          .sel_hi    (sel_hi[gi])
        );
      end else begin : g_body
        rmt_cell #(.IDX(gi), .CW(CW)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .bc        (bc),
          .count     (count),
          .mid_nxt   (mid_nxt),
          .odd_nxt   (odd_nxt),
          .prev_take (take[gi-1]),
          .prev_val  (val[gi-1]),
          .take      (take[gi]),
          .val       (val[gi]),
          .sel_lo    (sel_lo[gi]),
          .sel_hi    (sel_hi[gi])
        );
      end
    end
  endgenerate

  // Gather the flagged cells; at most one flag of each kind is set
  always_comb begin
    mid_lo = '0;
    mid_hi = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      mid_lo = mid_lo | (val[i] & {rmt_pkg::VALUE_W{sel_lo[i]}});
      mid_hi = mid_hi | (val[i] & {rmt_pkg::VALUE_W{sel_hi[i]}});
    end
  end

endmodule

/* rtl/core/running_median_tracker.sv */
// Running median tracker: insert samples into a sorted cell chain, query the median.
// Insert: the transfer loads the result register directly; a new item every cycle while the output drains.
// Query: taps gathered into lo/hi registers, then added into the result register; the next item waits for the add.
// The input is taken while idle and the result register is empty or draining in that cycle.
// Reset (synchronous, rst_n low) empties the store; sample cells are not cleared.
`timescale 1ns / 1ps
module running_median_tracker #(
  parameter int unsigned CAPACITY = rmt_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmt_in_if.sink    in_ch,
  rmt_out_if.source out_ch
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SUM  = 1'b1;

  logic             state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  rmt_pkg::med_t    med_r, med_nxt;
  rmt_pkg::status_t status_r, status_nxt;
  rmt_pkg::count_t  cnt_r, cnt_nxt;
  rmt_pkg::value_t  lo_r, lo_nxt;
  rmt_pkg::value_t  hi_r, hi_nxt;

  logic             in_xfer;
  logic             out_xfer;
  logic             full;
  rmt_pkg::bcast_t  bc;
  rmt_pkg::value_t  mid_lo, mid_hi;
  logic [CW+6:0]    cnt_ext;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign full        = (count_r >= CAP_C);

  // Broadcast the insert to the chain
  assign bc.ins   = in_xfer && (in_ch.cmd == rmt_pkg::CMD_INSERT) && !full;
  assign bc.value = in_ch.value;

  assign count_nxt = bc.ins ? count_r + CW'(1) : count_r;
  assign cnt_ext   = {7'd0, count_nxt};

  rmt_chain #(.CAPACITY(CAPACITY), .CW(CW)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .bc        (bc),
    .count     (count_r),
    .count_nxt (count_nxt),
    .mid_lo    (mid_lo),
    .mid_hi    (mid_hi)
  );

  // Sequence items and load the result register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    med_nxt       = med_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_nxt = cnt_ext[6:0];
          if (in_ch.cmd == rmt_pkg::CMD_INSERT) begin
            out_valid_nxt = 1'b1;
            med_nxt       = '0;
            status_nxt    = full ? rmt_pkg::STATUS_FULL : rmt_pkg::STATUS_OK;
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            med_nxt       = '0;
            status_nxt    = rmt_pkg::STATUS_EMPTY;
          end else begin
            lo_nxt    = mid_lo;
            hi_nxt    = mid_hi;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        out_valid_nxt = 1'b1;
        med_nxt       = {lo_r[rmt_pkg::VALUE_W-1], lo_r} + {hi_r[rmt_pkg::VALUE_W-1], hi_r};
        status_nxt    = rmt_pkg::STATUS_OK;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    med_r    <= med_nxt;
    status_r <= status_nxt;
    cnt_r    <= cnt_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = med_r;
  assign out_ch.status         = status_r;
  assign out_ch.count          = cnt_r;

endmodule
